@@ hdl/qtgs_pkg.sv @@
// Package for the trot gait sequencer: item and command types, register
// indexes, gait codes, angle constants and the angle-to-pulse function.
// No dependencies.
package qtgs_pkg;

  localparam int TimeBitsDef   = 32;
  localparam int CmdQueueDepth = 2;
  localparam int NumCh         = 10;
  localparam int PulseW        = 10;
  localparam int AngW          = 8;
  localparam int PeriodW       = 16;
  localparam int DeadzoneW     = 7;
  localparam int CfgIdxW       = 2;
  localparam int CfgDataW      = 16;
  localparam int TimeInW       = 32;

  localparam logic [PeriodW-1:0]   PeriodNormalRst = 16'd1000;
  localparam logic [PeriodW-1:0]   PeriodFastRst   = 16'd750;
  localparam logic [DeadzoneW-1:0] DeadzoneRst     = 7'd10;
  localparam logic [AngW-1:0]      HeadRst         = 8'd110;
  localparam logic [AngW-1:0]      HeadMax         = 8'd180;
  localparam logic [PulseW-1:0]    PulseBase       = 10'd125;

  localparam logic [AngW-1:0] AngZero   = 8'd0;
  localparam logic [AngW-1:0] AngCrouch = 8'd30;
  localparam logic [AngW-1:0] AngClaw   = 8'd45;
  localparam logic [AngW-1:0] AngWideLo = 8'd60;
  localparam logic [AngW-1:0] AngLift   = 8'd60;
  localparam logic [AngW-1:0] AngStand  = 8'd60;
  localparam logic [AngW-1:0] AngNarLo  = 8'd80;
  localparam logic [AngW-1:0] AngMid    = 8'd90;
  localparam logic [AngW-1:0] AngNarHi  = 8'd100;
  localparam logic [AngW-1:0] AngWideHi = 8'd120;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PERIOD_NORMAL = 2'd0,
    CFG_PERIOD_FAST   = 2'd1,
    CFG_DEADZONE      = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    GAIT_BACK  = 3'd0,
    GAIT_FWD   = 3'd1,
    GAIT_RIGHT = 3'd2,
    GAIT_LEFT  = 3'd3,
    GAIT_IDLE  = 3'd4
  } gait_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_APPLY
  } back_state_e;

  typedef struct packed {
    logic               connected;
    logic [TimeInW-1:0] time_ms;
    logic signed [7:0]  stick_y;
    logic signed [7:0]  stick_x;
    logic               hold_crouch;
    logic               hold_fast;
    logic               hold_head_up;
    logic               hold_head_down;
    logic               stride_press;
    logic               claw_open;
  } in_item_t;

  typedef struct packed {
    logic [PulseW-1:0] pulse_thigh_a;
    logic [PulseW-1:0] pulse_leg_a;
    logic [PulseW-1:0] pulse_thigh_b;
    logic [PulseW-1:0] pulse_leg_b;
    logic [PulseW-1:0] pulse_thigh_c;
    logic [PulseW-1:0] pulse_leg_c;
    logic [PulseW-1:0] pulse_thigh_d;
    logic [PulseW-1:0] pulse_leg_d;
    logic [PulseW-1:0] pulse_head;
    logic [PulseW-1:0] pulse_claw;
  } res_item_t;

  // classified pass, time travels beside it
  typedef struct packed {
    logic                connected;
    logic [AngW-1:0]     head_angle;
    logic                wide_stride;
    logic                crouch;
    logic                claw_open;
    gait_e               gait;
    logic [PeriodW-1:0]  period;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // bit k is gait table entry k
  function automatic logic [3:0] gait_sel(gait_e g);
    logic [3:0] s;
    case (g)
      GAIT_BACK:  s = 4'b0011;
      GAIT_FWD:   s = 4'b1100;
      GAIT_RIGHT: s = 4'b0110;
      GAIT_LEFT:  s = 4'b1001;
      default:    s = 4'b0000;
    endcase
    return s;
  endfunction

  function automatic logic [PulseW-1:0] ang_to_pulse(logic [AngW-1:0] a);
    logic [AngW+2:0] m;
    m = {3'b000, a} + {1'b0, a, 2'b00};
    return PulseW'(m >> 1) + PulseBase;
  endfunction

endpackage

@@ hdl/quadruped_trot_gait_sequencer_core.sv @@
// Top level of the trot gait sequencer: front end, command queue, back end.
// Depends on qtgs_pkg, qtgs_front, qtgs_fifo, qtgs_back.
//
// Usage: each control pass is pushed as one request on item_i with push;
// it is taken at a clock edge with push high and full low. Results come
// out queue style: while empty is low res_item_o holds the ten channel
// pulses of the oldest finished pass, taken at an edge with pop high.
// Configuration (periods, deadzone) is written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i while the block is idle; takes effect at once.
// A pass goes from the queue through the bit-serial remainder of its
// time (TIME_BITS bits, capped at 32) by period in the back end to the
// result register; the next pass is taken only once the last is applied.
// The front end keeps accepting into a two-entry queue while the back end
// is busy or the result waits; when the result is not popped the back end
// holds its finished pass and full rises once the queue fills.
// Reset clears all channel pulses to 0, head angle to 110, narrow stride,
// and loads the register defaults.
module quadruped_trot_gait_sequencer_core #(
  parameter int TIME_BITS   = qtgs_pkg::TimeBitsDef,
  parameter int QUEUE_DEPTH = qtgs_pkg::CmdQueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [qtgs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [qtgs_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          push,
  output logic                          full,
  input  qtgs_pkg::in_item_t            item_i,
  output logic                          empty,
  input  logic                          pop,
  output qtgs_pkg::res_item_t           res_item_o
);

  localparam int TimeW = (TIME_BITS < qtgs_pkg::TimeInW) ? TIME_BITS : qtgs_pkg::TimeInW;
  localparam int QW    = $bits(qtgs_pkg::cmd_t) + TimeW;

  qtgs_pkg::q_status_t q_stat;
  qtgs_pkg::cmd_t      enq_cmd, deq_cmd;
  logic [TimeW-1:0]    enq_time, deq_time;
  logic                enq, deq;

  assign full = q_stat.full;

  qtgs_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .item_i      (item_i),
    .q_stat_i    (q_stat),
    .enq_o       (enq),
    .cmd_o       (enq_cmd),
    .time_o      (enq_time)
  );

  qtgs_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (enq),
    .wdata_i ({enq_cmd, enq_time}),
    .rd_i    (deq),
    .rdata_o ({deq_cmd, deq_time}),
    .stat_o  (q_stat)
  );

  qtgs_back #(
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .cmd_i    (deq_cmd),
    .time_i   (deq_time),
    .deq_o    (deq),
    .pop_i    (pop),
    .empty_o  (empty),
    .res_o    (res_item_o)
  );

endmodule

@@ hdl/qtgs_front.sv @@
// Front end: configuration registers, head and stride state, gait
// classification of each accepted pass. Depends on qtgs_pkg.
module qtgs_front #(
  parameter int TIME_BITS = qtgs_pkg::TimeBitsDef,
  localparam int TimeW = (TIME_BITS < qtgs_pkg::TimeInW) ? TIME_BITS : qtgs_pkg::TimeInW
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [qtgs_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [qtgs_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                            push_i,
  input  qtgs_pkg::in_item_t              item_i,
  input  qtgs_pkg::q_status_t             q_stat_i,
  output logic                            enq_o,
  output qtgs_pkg::cmd_t                  cmd_o,
  output logic [TimeW-1:0]                time_o
);

  logic [qtgs_pkg::PeriodW-1:0]   period_normal_q, period_fast_q;
  logic [qtgs_pkg::DeadzoneW-1:0] deadzone_q;
  logic [qtgs_pkg::AngW-1:0]      head_q, head_d, head_dec;
  logic                           wide_q, wide_d;
  logic signed [8:0]              ys, xs, dzs;
  qtgs_pkg::gait_e                gait;

  assign enq_o = push_i & ~q_stat_i.full;

  always_comb begin
    head_dec = head_q;
    if (item_i.hold_head_down && head_q != '0) begin
      head_dec = head_q - 1'b1;
    end
    head_d = head_dec;
    if (item_i.hold_head_up && head_dec < qtgs_pkg::HeadMax) begin
      head_d = head_dec + 1'b1;
    end
    wide_d = wide_q ^ item_i.stride_press;
  end

  always_comb begin
    ys  = {item_i.stick_y[7], item_i.stick_y};
    xs  = {item_i.stick_x[7], item_i.stick_x};
    dzs = {2'b00, deadzone_q};
    if (ys > dzs) begin
      gait = qtgs_pkg::GAIT_BACK;
    end else if (ys < -dzs) begin
      gait = qtgs_pkg::GAIT_FWD;
    end else if (xs > dzs) begin
      gait = qtgs_pkg::GAIT_RIGHT;
    end else if (xs < -dzs) begin
      gait = qtgs_pkg::GAIT_LEFT;
    end else begin
      gait = qtgs_pkg::GAIT_IDLE;
    end
  end

  always_comb begin
    cmd_o.connected   = item_i.connected;
    cmd_o.head_angle  = head_d;
    cmd_o.wide_stride = wide_d;
    cmd_o.crouch      = item_i.hold_crouch;
    cmd_o.claw_open   = item_i.claw_open;
    cmd_o.gait        = gait;
    cmd_o.period      = item_i.hold_fast ? period_fast_q : period_normal_q;
    time_o            = item_i.time_ms[TimeW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_normal_q <= qtgs_pkg::PeriodNormalRst;
      period_fast_q   <= qtgs_pkg::PeriodFastRst;
      deadzone_q      <= qtgs_pkg::DeadzoneRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        qtgs_pkg::CFG_PERIOD_NORMAL: period_normal_q <= cfg_wdata_i;
        qtgs_pkg::CFG_PERIOD_FAST:   period_fast_q   <= cfg_wdata_i;
        qtgs_pkg::CFG_DEADZONE:      deadzone_q      <= cfg_wdata_i[qtgs_pkg::DeadzoneW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= qtgs_pkg::HeadRst;
      wide_q <= 1'b0;
    end else if (enq_o && item_i.connected) begin
      head_q <= head_d;
      wide_q <= wide_d;
    end
  end

endmodule

@@ hdl/qtgs_fifo.sv @@
// Short command queue between front and back end.
// Depends on qtgs_pkg for the status struct.
module qtgs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = qtgs_pkg::CmdQueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  logic [WIDTH-1:0]    wdata_i,
  input  logic                rd_i,
  output logic [WIDTH-1:0]    rdata_o,
  output qtgs_pkg::q_status_t stat_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_wr, do_rd;

  assign stat_o.full  = (cnt_q == CntW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_wr   = wr_i & ~stat_o.full;
  assign do_rd   = rd_i & ~stat_o.empty;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ hdl/qtgs_back.sv @@
// Back end: serial time-mod-period, quarter select, channel pulse state
// and the result register. Depends on qtgs_pkg.
module qtgs_back #(
  parameter int TIME_BITS = qtgs_pkg::TimeBitsDef,
  localparam int TimeW = (TIME_BITS < qtgs_pkg::TimeInW) ? TIME_BITS : qtgs_pkg::TimeInW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qtgs_pkg::q_status_t q_stat_i,
  input  qtgs_pkg::cmd_t      cmd_i,
  input  logic [TimeW-1:0]    time_i,
  output logic                deq_o,
  input  logic                pop_i,
  output logic                empty_o,
  output qtgs_pkg::res_item_t res_o
);

  localparam int CntW = $clog2(TimeW);
  localparam int PW   = qtgs_pkg::PeriodW;
  localparam int NCh  = qtgs_pkg::NumCh;

  typedef logic [NCh-1:0][qtgs_pkg::PulseW-1:0] pulse_vec_t;

  qtgs_pkg::back_state_e state_q, state_d;
  qtgs_pkg::cmd_t        cmd_q;
  logic [TimeW-1:0]      tsh_q;
  logic [CntW-1:0]       cnt_q;
  logic [PW-1:0]         rem_q, rem_d;
  logic [PW:0]           trial;
  pulse_vec_t            ch_q, ch_d;
  logic                  out_valid_q, out_free;
  logic                  load, step, apply_en, last;

  assign out_free = ~out_valid_q | pop_i;
  assign last     = (cnt_q == CntW'(TimeW - 1));
  assign empty_o  = ~out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      qtgs_pkg::BK_IDLE:  if (!q_stat_i.empty) state_d = qtgs_pkg::BK_DIV;
      qtgs_pkg::BK_DIV:   if (last) state_d = qtgs_pkg::BK_APPLY;
      qtgs_pkg::BK_APPLY: if (out_free) state_d = qtgs_pkg::BK_IDLE;
      default:            state_d = qtgs_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    load     = 1'b0;
    step     = 1'b0;
    apply_en = 1'b0;
    case (state_q)
      qtgs_pkg::BK_IDLE:  load = ~q_stat_i.empty;
      qtgs_pkg::BK_DIV:   step = 1'b1;
      qtgs_pkg::BK_APPLY: apply_en = out_free;
      default: ;
    endcase
  end

  assign deq_o = load;

  // restoring remainder, one time bit per cycle
  always_comb begin
    trial = {rem_q, tsh_q[TimeW-1]};
    if (cmd_q.period == '0) begin
      rem_d = '0;
    end else if (trial >= {1'b0, cmd_q.period}) begin
      rem_d = PW'(trial - {1'b0, cmd_q.period});
    end else begin
      rem_d = trial[PW-1:0];
    end
  end

  always_comb begin
    logic [PW-1:0]   q1, q2, q3;
    logic [PW+1:0]   p3;
    logic [3:0]      s;
    logic [qtgs_pkg::AngW-1:0] lo, hi, o1, o3, o5, o7;
    logic [qtgs_pkg::AngW-1:0] ang [8];
    logic [7:0]      wr;
    q1 = cmd_q.period >> 2;
    q2 = cmd_q.period >> 1;
    p3 = {2'b00, cmd_q.period} + {1'b0, cmd_q.period, 1'b0};
    q3 = PW'(p3 >> 2);
    s  = qtgs_pkg::gait_sel(cmd_q.gait);
    lo = cmd_q.wide_stride ? qtgs_pkg::AngWideLo : qtgs_pkg::AngNarLo;
    hi = cmd_q.wide_stride ? qtgs_pkg::AngWideHi : qtgs_pkg::AngNarHi;
    if (cmd_q.crouch) begin
      o1 = qtgs_pkg::AngCrouch; o3 = qtgs_pkg::AngCrouch;
      o5 = qtgs_pkg::AngCrouch; o7 = qtgs_pkg::AngCrouch;
    end else begin
      o1 = qtgs_pkg::AngStand; o3 = qtgs_pkg::AngZero;
      o5 = qtgs_pkg::AngStand; o7 = qtgs_pkg::AngZero;
    end
    for (int k = 0; k < 8; k++) begin
      ang[k] = qtgs_pkg::AngMid;
    end
    wr = '0;
    if (cmd_q.gait == qtgs_pkg::GAIT_IDLE) begin
      wr = 8'hFF;
      ang[1] = o1; ang[3] = o3; ang[5] = o5; ang[7] = o7;
    end else if (rem_q < q1) begin
      wr = 8'b0111_0111;
      ang[1] = qtgs_pkg::AngZero; ang[5] = qtgs_pkg::AngZero;
      ang[2] = s[2] ? hi : lo;
      ang[6] = s[3] ? lo : hi;
    end else if (rem_q < q2) begin
      wr = 8'b0011_0011;
      ang[0] = s[0] ? hi : lo;
      ang[4] = s[1] ? lo : hi;
      ang[1] = o1; ang[5] = o5;
    end else if (rem_q < q3) begin
      wr = 8'b1101_1101;
      ang[3] = qtgs_pkg::AngLift; ang[7] = qtgs_pkg::AngLift;
      ang[0] = s[0] ? lo : hi;
      ang[4] = s[1] ? hi : lo;
    end else begin
      wr = 8'b1100_1100;
      ang[2] = s[2] ? lo : hi;
      ang[6] = s[3] ? hi : lo;
      ang[3] = o3; ang[7] = o7;
    end
    ch_d = ch_q;
    if (cmd_q.connected) begin
      for (int k = 0; k < 8; k++) begin
        if (wr[k]) ch_d[k] = qtgs_pkg::ang_to_pulse(ang[k]);
      end
      ch_d[8] = qtgs_pkg::ang_to_pulse(cmd_q.head_angle);
    end
    ch_d[9] = qtgs_pkg::ang_to_pulse(cmd_q.claw_open ? qtgs_pkg::AngClaw : qtgs_pkg::AngZero);
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= cmd_i;
      tsh_q <= time_i;
      rem_q <= '0;
      cnt_q <= '0;
    end else if (step) begin
      tsh_q <= tsh_q << 1;
      rem_q <= rem_d;
      cnt_q <= cnt_q + 1'b1;
    end
    if (apply_en) begin
      res_o.pulse_thigh_a <= ch_d[0];
      res_o.pulse_leg_a   <= ch_d[1];
      res_o.pulse_thigh_b <= ch_d[2];
      res_o.pulse_leg_b   <= ch_d[3];
      res_o.pulse_thigh_c <= ch_d[4];
      res_o.pulse_leg_c   <= ch_d[5];
      res_o.pulse_thigh_d <= ch_d[6];
      res_o.pulse_leg_d   <= ch_d[7];
      res_o.pulse_head    <= ch_d[8];
      res_o.pulse_claw    <= ch_d[9];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qtgs_pkg::BK_IDLE;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (apply_en) begin
        ch_q        <= ch_d;
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

@@ tb/tb_quadruped_trot_gait_sequencer_core.sv @@
// Self-checking testbench for quadruped_trot_gait_sequencer_core: directed
// and random control passes, predicted channel pulses checked per result.
// Depends on qtgs_pkg and the core RTL.
module tb_quadruped_trot_gait_sequencer_core;
  import qtgs_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int HoldOffCycles = 300;
  localparam int PassesPerSetting = 165;
  localparam int NumSettings = 9;

  // button bits for mk_pass: {crouch, fast, head_up, head_down, stride, claw}
  localparam logic [5:0] BtnCrouch = 6'b100000;
  localparam logic [5:0] BtnFast   = 6'b010000;
  localparam logic [5:0] BtnUp     = 6'b001000;
  localparam logic [5:0] BtnDown   = 6'b000100;
  localparam logic [5:0] BtnStride = 6'b000010;
  localparam logic [5:0] BtnClaw   = 6'b000001;

  class pulse_scoreboard;
    res_item_t pending[$];
    int errors;
    logic [PeriodW-1:0] period_normal;
    logic [PeriodW-1:0] period_fast;
    logic [DeadzoneW-1:0] deadzone;
    logic [AngW-1:0] head_angle;
    bit wide_stride;
    logic [PulseW-1:0] chan[NumCh];

    function new();
      errors = 0;
      period_normal = PeriodNormalRst;
      period_fast = PeriodFastRst;
      deadzone = DeadzoneRst;
      head_angle = HeadRst;
      wide_stride = 1'b0;
      foreach (chan[i]) chan[i] = '0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] v);
      case (idx)
        CFG_PERIOD_NORMAL: period_normal = v;
        CFG_PERIOD_FAST:   period_fast = v;
        CFG_DEADZONE:      deadzone = v[DeadzoneW-1:0];
        default: ;
      endcase
    endfunction

    function logic [PulseW-1:0] angle_pulse(logic [AngW-1:0] ang);
      return PulseW'((32'(ang) * 5) / 2 + 125);
    endfunction

    function void note_pass(in_item_t it);
      int y, x, dz;
      int unsigned p, ph;
      logic [AngW-1:0] lo, hi, o1, o3, o5, o7;
      gait_e gait;
      bit s0, s1, s2, s3;
      if (it.connected) begin
        if (it.hold_head_down && head_angle != 0) head_angle = head_angle - 1'b1;
        if (it.hold_head_up && head_angle < HeadMax) head_angle = head_angle + 1'b1;
        chan[8] = angle_pulse(head_angle);
        if (it.stride_press) wide_stride = !wide_stride;
        lo = wide_stride ? AngWideLo : AngNarLo;
        hi = wide_stride ? AngWideHi : AngNarHi;
        if (it.hold_crouch) begin
          o1 = AngCrouch; o3 = AngCrouch; o5 = AngCrouch; o7 = AngCrouch;
        end else begin
          o1 = AngStand; o3 = AngZero; o5 = AngStand; o7 = AngZero;
        end
        p = 32'(it.hold_fast ? period_fast : period_normal);
        ph = (p == 0) ? 0 : it.time_ms % p;
        y = int'($signed(it.stick_y));
        x = int'($signed(it.stick_x));
        dz = int'(deadzone);
        if (y > dz) gait = GAIT_BACK;
        else if (y < -dz) gait = GAIT_FWD;
        else if (x > dz) gait = GAIT_RIGHT;
        else if (x < -dz) gait = GAIT_LEFT;
        else gait = GAIT_IDLE;
        case (gait)
          GAIT_BACK:  {s0, s1, s2, s3} = 4'b1100;
          GAIT_FWD:   {s0, s1, s2, s3} = 4'b0011;
          GAIT_RIGHT: {s0, s1, s2, s3} = 4'b0110;
          GAIT_LEFT:  {s0, s1, s2, s3} = 4'b1001;
          default:    {s0, s1, s2, s3} = 4'b0000;
        endcase
        if (gait == GAIT_IDLE) begin
          chan[0] = angle_pulse(AngMid); chan[2] = angle_pulse(AngMid);
          chan[4] = angle_pulse(AngMid); chan[6] = angle_pulse(AngMid);
          chan[1] = angle_pulse(o1); chan[3] = angle_pulse(o3);
          chan[5] = angle_pulse(o5); chan[7] = angle_pulse(o7);
        end else if (ph < p / 4) begin
          chan[1] = angle_pulse(AngZero); chan[5] = angle_pulse(AngZero);
          chan[0] = angle_pulse(AngMid); chan[4] = angle_pulse(AngMid);
          chan[2] = angle_pulse(s2 ? hi : lo);
          chan[6] = angle_pulse(s3 ? lo : hi);
        end else if (ph < (2 * p) / 4) begin
          chan[0] = angle_pulse(s0 ? hi : lo);
          chan[4] = angle_pulse(s1 ? lo : hi);
          chan[1] = angle_pulse(o1); chan[5] = angle_pulse(o5);
        end else if (ph < (3 * p) / 4) begin
          chan[3] = angle_pulse(AngLift); chan[7] = angle_pulse(AngLift);
          chan[2] = angle_pulse(AngMid); chan[6] = angle_pulse(AngMid);
          chan[0] = angle_pulse(s0 ? lo : hi);
          chan[4] = angle_pulse(s1 ? hi : lo);
        end else begin
          chan[2] = angle_pulse(s2 ? lo : hi);
          chan[6] = angle_pulse(s3 ? hi : lo);
          chan[3] = angle_pulse(o3); chan[7] = angle_pulse(o7);
        end
      end
      chan[9] = angle_pulse(it.claw_open ? AngClaw : AngZero);
      pending.push_back({chan[0], chan[1], chan[2], chan[3], chan[4],
                         chan[5], chan[6], chan[7], chan[8], chan[9]});
    endfunction

    function void cmp_field(string name, logic [PulseW-1:0] want, logic [PulseW-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_pulses(res_item_t got);
      res_item_t want;
      if (pending.size() == 0) begin
        $error("pulse result with no request outstanding");
        errors++;
        return;
      end
      want = pending.pop_front();
      cmp_field("pulse_thigh_a", want.pulse_thigh_a, got.pulse_thigh_a);
      cmp_field("pulse_leg_a", want.pulse_leg_a, got.pulse_leg_a);
      cmp_field("pulse_thigh_b", want.pulse_thigh_b, got.pulse_thigh_b);
      cmp_field("pulse_leg_b", want.pulse_leg_b, got.pulse_leg_b);
      cmp_field("pulse_thigh_c", want.pulse_thigh_c, got.pulse_thigh_c);
      cmp_field("pulse_leg_c", want.pulse_leg_c, got.pulse_leg_c);
      cmp_field("pulse_thigh_d", want.pulse_thigh_d, got.pulse_thigh_d);
      cmp_field("pulse_leg_d", want.pulse_leg_d, got.pulse_leg_d);
      cmp_field("pulse_head", want.pulse_head, got.pulse_head);
      cmp_field("pulse_claw", want.pulse_claw, got.pulse_claw);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                push;
  logic                full;
  in_item_t            item_i;
  logic                empty;
  logic                pop;
  res_item_t           res_item_o;

  pulse_scoreboard sb;
  bit send_burst, recv_burst;
  int passes_sent, results_seen, idle_cycles;
  int head_trend;
  int pn_set[NumSettings], pf_set[NumSettings], dz_set[NumSettings];

  quadruped_trot_gait_sequencer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .empty       (empty),
    .pop         (pop),
    .res_item_o  (res_item_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic in_item_t mk_pass(bit conn, logic [31:0] t, int y, int x,
                                       logic [5:0] btn);
    in_item_t it;
    it.connected = conn;
    it.time_ms = t;
    it.stick_y = 8'(y);
    it.stick_x = 8'(x);
    {it.hold_crouch, it.hold_fast, it.hold_head_up, it.hold_head_down,
     it.stride_press, it.claw_open} = btn;
    return it;
  endfunction

  // half any value, a quarter right around the deadzone edge, a quarter zero
  function automatic logic signed [7:0] rand_stick(int dz);
    int v;
    case ($urandom_range(0, 3))
      0: v = 0;
      1: v = dz + int'($urandom_range(0, 2)) - 1;
      default: return 8'($urandom());
    endcase
    if ($urandom_range(0, 1)) v = -v;
    if (v > 127) v = 127;
    if (v < -128) v = -128;
    return 8'(v);
  endfunction

  task automatic send_pass(input in_item_t it);
    int gap;
    if (passes_sent % 50 == 0) send_burst = ($urandom_range(0, 3) == 0);
    gap = send_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_pass(it);
    passes_sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [CfgDataW-1:0] pn, input logic [CfgDataW-1:0] pf,
                              input logic [CfgDataW-1:0] dz);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_PERIOD_NORMAL;
    cfg_wdata_i <= pn;
    @(posedge clk_i);
    sb.write_reg(CFG_PERIOD_NORMAL, pn);
    cfg_idx_i <= CFG_PERIOD_FAST;
    cfg_wdata_i <= pf;
    @(posedge clk_i);
    sb.write_reg(CFG_PERIOD_FAST, pf);
    cfg_idx_i <= CFG_DEADZONE;
    cfg_wdata_i <= dz;
    @(posedge clk_i);
    sb.write_reg(CFG_DEADZONE, dz);
    cfg_we_i <= 1'b0;
  endtask

  // result side; one long hold-off lets the block fill and stall requests
  initial begin
    int gap;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (results_seen % 50 == 0) recv_burst = ($urandom_range(0, 3) == 0);
      gap = recv_burst ? 0 : $urandom_range(0, 9);
      if (results_seen == 400) gap += HoldOffCycles;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      sb.check_pulses(res_item_o);
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || cfg_we_i) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [5:0] btn;
    logic [31:0] t;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_PERIOD_NORMAL;
    cfg_wdata_i = '0;
    push = 1'b0;
    pop = 1'b0;
    item_i = '0;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed passes at reset settings: period 1000 / 750, deadzone 10
    send_pass(mk_pass(0, 0, 0, 0, BtnClaw));
    send_pass(mk_pass(0, 5, 50, 0, BtnUp | BtnStride));
    send_pass(mk_pass(1, 0, 0, 0, '0));
    send_pass(mk_pass(1, 100, 127, 0, '0));
    send_pass(mk_pass(1, 300, 127, 0, '0));
    send_pass(mk_pass(1, 600, 127, 0, BtnClaw));
    send_pass(mk_pass(1, 900, 127, 0, '0));
    send_pass(mk_pass(1, 32'hFFFF_FFFF, -128, 0, BtnCrouch));
    send_pass(mk_pass(1, 1010, -128, 0, BtnCrouch));
    send_pass(mk_pass(1, 1510, -128, 0, BtnCrouch));
    send_pass(mk_pass(1, 1760, -128, 0, BtnCrouch));
    send_pass(mk_pass(1, 260, 0, 127, BtnStride));
    send_pass(mk_pass(1, 990, 0, 127, '0));
    send_pass(mk_pass(1, 10, 0, -128, BtnFast));
    send_pass(mk_pass(1, 620, 0, -128, BtnFast | BtnStride));
    send_pass(mk_pass(1, 400, 10, 11, '0));
    send_pass(mk_pass(1, 55, -10, -10, BtnUp | BtnDown));
    send_pass(mk_pass(1, 700, 11, -128, BtnDown));
    send_pass(mk_pass(1, 999, -11, 127, BtnFast | BtnUp));
    send_pass(mk_pass(1, 0, 0, -11, BtnCrouch | BtnFast));
    send_pass(mk_pass(0, 32'h8000_0000, -128, 127, 6'b111111));
    drain();

    pn_set = '{4, 65535, 0, 1, 0, 0, 0, 0, 1000};
    pf_set = '{65535, 4, 3, 2, 0, 0, 0, 0, 750};
    dz_set = '{0, 127, 64, 5, 0, 0, 0, 0, 10};
    for (int s = 4; s < 8; s++) begin
      pn_set[s] = (s == 7) ? $urandom_range(4, 65535) : $urandom_range(4, 3000);
      pf_set[s] = (s == 7) ? $urandom_range(4, 65535) : $urandom_range(4, 3000);
      dz_set[s] = $urandom_range(0, 127);
    end

    for (int s = 0; s < NumSettings; s++) begin
      program_regs(CfgDataW'(pn_set[s]), CfgDataW'(pf_set[s]), CfgDataW'(dz_set[s]));
      for (int n = 0; n < PassesPerSetting; n++) begin
        // head drifts up, down or wanders so both end stops get reached
        if (n % 150 == 0) head_trend = $urandom_range(0, 2);
        case (head_trend)
          1: btn[3:2] = {($urandom_range(0, 9) != 0), ($urandom_range(0, 9) == 0)};
          2: btn[3:2] = {($urandom_range(0, 9) == 0), ($urandom_range(0, 9) != 0)};
          default: btn[3:2] = 2'($urandom());
        endcase
        btn[5:4] = 2'($urandom());
        btn[1] = ($urandom_range(0, 3) == 0);
        btn[0] = ($urandom_range(0, 1) != 0);
        case ($urandom_range(0, 5))
          0: t = $urandom_range(0, 3);
          1: t = ~32'($urandom_range(0, 3));
          default: t = $urandom();
        endcase
        send_pass(mk_pass($urandom_range(0, 9) != 0, t, rand_stick(dz_set[s]),
                          rand_stick(dz_set[s]), btn));
      end
      drain();
    end

    repeat (40) @(posedge clk_i);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
